/* hdl/smoothed_fractional_predelay_core_defines.svh */
// Assertion macros shared by the pre-delay core RTL.
`ifndef SMOOTHED_FRACTIONAL_PREDELAY_CORE_DEFINES_SVH
`define SMOOTHED_FRACTIONAL_PREDELAY_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sfpd_pkg.sv */
// Shared constants and types of the smoothed fractional pre-delay core.
package sfpd_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int DELAY_BITS      = 30;
    localparam int RAMP_BITS       = 16;
    localparam int CFG_DATA_BITS   = DELAY_BITS;
    localparam int DIV_CNT_BITS    = $clog2(DELAY_BITS + 1);

    localparam int DEF_STORE_DEPTH = 16384;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(65536);
    localparam logic [RAMP_BITS-1:0]  RAMP_RESET  = RAMP_BITS'(2400);

    typedef enum logic [1:0] {
        CFG_TARGET,
        CFG_RAMP,
        CFG_STEREO,
        CFG_BYPASS
    } t_cfg_idx;

    typedef struct packed {
        logic we_left;
        logic we_right;
        logic re;
    } t_store_ctrl;

endpackage

/* hdl/sfpd_divider.sv */
// Restoring divider that finds the signed glide step one quotient bit per cycle.
module sfpd_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [sfpd_pkg::DELAY_BITS:0] i_num,
    input  logic [sfpd_pkg::RAMP_BITS-1:0]      i_den,
    output logic                                o_done,
    output logic signed [sfpd_pkg::DELAY_BITS:0] o_quot
);
    import sfpd_pkg::*;

    logic                      r_busy;
    logic                      r_done;
    logic [DIV_CNT_BITS-1:0]   r_cnt;
    logic                      r_neg;
    logic [DELAY_BITS-1:0]     r_quo;
    logic [RAMP_BITS-1:0]      r_rem;
    logic [RAMP_BITS-1:0]      r_den;

    logic signed [DELAY_BITS:0] abs_num;
    logic [RAMP_BITS:0]         trial;
    logic [RAMP_BITS:0]         trial_diff;
    logic                       fits;
    logic [RAMP_BITS-1:0]       rem_next;

    assign abs_num    = i_num[DELAY_BITS] ? -i_num : i_num;
    assign trial      = {r_rem, r_quo[DELAY_BITS-1]};
    assign trial_diff = trial - {1'b0, r_den};
    assign fits       = trial >= {1'b0, r_den};
    assign rem_next   = fits ? trial_diff[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_BITS'(DELAY_BITS);
            r_neg  <= i_num[DELAY_BITS];
            r_quo  <= abs_num[DELAY_BITS-1:0];
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[DELAY_BITS-2:0], fits};
            r_cnt <= r_cnt - DIV_CNT_BITS'(1);
            if (r_cnt == DIV_CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

/* hdl/sfpd_store.sv */
// Left and right sample memories with one write port and two registered read ports each.
module sfpd_store #(
    parameter int STORE_DEPTH = sfpd_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = sfpd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  sfpd_pkg::t_store_ctrl                 i_ctrl,
    input  logic [$clog2(STORE_DEPTH)-1:0]        i_waddr,
    input  logic signed [SAMPLE_BITS-1:0]         i_wleft,
    input  logic signed [SAMPLE_BITS-1:0]         i_wright,
    input  logic [$clog2(STORE_DEPTH)-1:0]        i_raddr1,
    input  logic [$clog2(STORE_DEPTH)-1:0]        i_raddr2,
    output logic signed [SAMPLE_BITS-1:0]         o_left1,
    output logic signed [SAMPLE_BITS-1:0]         o_left2,
    output logic signed [SAMPLE_BITS-1:0]         o_right1,
    output logic signed [SAMPLE_BITS-1:0]         o_right2
);
    import sfpd_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem_left  [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_mem_right [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_left) begin
            r_mem_left[i_waddr] <= i_wleft;
        end
        if (i_ctrl.we_right) begin
            r_mem_right[i_waddr] <= i_wright;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.re) begin
            o_left1  <= r_mem_left[i_raddr1];
            o_left2  <= r_mem_left[i_raddr2];
            o_right1 <= r_mem_right[i_raddr1];
            o_right2 <= r_mem_right[i_raddr2];
        end
    end

endmodule

/* hdl/sfpd_interp.sv */
// Three-stage linear interpolation lane: difference, product, rounded-down sum.
module sfpd_interp #(
    parameter int SAMPLE_BITS = sfpd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [SAMPLE_BITS-1:0]      i_a,
    input  logic signed [SAMPLE_BITS-1:0]      i_b,
    input  logic [sfpd_pkg::FRAC_BITS-1:0]     i_frac,
    output logic                               o_done,
    output logic signed [SAMPLE_BITS-1:0]      o_y
);
    import sfpd_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic signed [SAMPLE_BITS:0]   r_diff;
    logic signed [SAMPLE_BITS-1:0] r_a1;
    logic signed [SAMPLE_BITS-1:0] r_a2;
    logic [FRAC_BITS-1:0]          r_frac1;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [SAMPLE_BITS-1:0] r_y;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic [SAMPLE_BITS+1:0]        prod_hi;

    assign diff    = $signed({i_b[SAMPLE_BITS-1], i_b}) - $signed({i_a[SAMPLE_BITS-1], i_a});
    assign frac_s  = $signed({1'b0, r_frac1});
    assign prod_hi = r_prod[PROD_BITS-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_start) begin
                r_diff  <= diff;
                r_a1    <= i_a;
                r_frac1 <= i_frac;
            end
            if (r_v1) begin
                r_prod <= r_diff * frac_s;
                r_a2   <= r_a1;
            end
            if (r_v2) begin
                r_y <= r_a2 + $signed(prod_hi[SAMPLE_BITS-1:0]);
            end
        end
    end

    assign o_done = r_v3;
    assign o_y    = r_y;

endmodule

/* hdl/smoothed_fractional_predelay_core.sv */
// Top level of the smoothed fractional pre-delay core: control sequencer and register file.
// A request passes GLIDE, WRITE, READ, LOAD, WAIT and OUT; the input stalls until it is back in IDLE.
// A new target with a nonzero ramp first waits in DIV for the bit-serial step divider.
// In bypass a request goes from IDLE straight to OUT, passing through the output register only.
// Memory write, then the two-address read, then the 3-stage interpolator make up the normal path.
// Synchronous active-low reset clears control state; the sample memories are not swept, and
// reads of entries not yet written since reset return zero by a wrap flag on the write index.
`include "smoothed_fractional_predelay_core_defines.svh"

module smoothed_fractional_predelay_core #(
    parameter int STORE_DEPTH = sfpd_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = sfpd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  sfpd_pkg::t_cfg_idx                     i_cfg_idx,
    input  logic [sfpd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]          o_left_out,
    output logic signed [SAMPLE_BITS-1:0]          o_right_out
);
    import sfpd_pkg::*;

    localparam int IDX_BITS = $clog2(STORE_DEPTH);
    localparam int SUM_W    = IDX_BITS + FRAC_BITS + 1;
    localparam longint LIMIT_FULL = longint'(STORE_DEPTH - 4) << FRAC_BITS;
    localparam longint DELAY_MAX  = (longint'(1) << DELAY_BITS) - 1;
    localparam logic [DELAY_BITS-1:0] LIMIT =
        DELAY_BITS'((LIMIT_FULL > DELAY_MAX) ? DELAY_MAX : LIMIT_FULL);
    localparam logic [SUM_W-1:0] SPAN = SUM_W'(longint'(STORE_DEPTH) << FRAC_BITS);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(STORE_DEPTH - 1);
    localparam logic signed [SAMPLE_BITS-1:0] CLAMP_HI = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [SAMPLE_BITS-1:0] CLAMP_LO = -CLAMP_HI;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GLIDE,
        S_WRITE,
        S_READ,
        S_LOAD,
        S_WAIT,
        S_OUT
    } t_state;

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        if (v > CLAMP_HI) begin
            return CLAMP_HI;
        end else if (v < CLAMP_LO) begin
            return CLAMP_LO;
        end
        return v;
    endfunction

    logic [DELAY_BITS-1:0]         r_target;
    logic [RAMP_BITS-1:0]          r_ramp;
    logic                          r_stereo;
    logic                          r_bypass;

    t_state                        r_state;
    logic [DELAY_BITS-1:0]         r_cur;
    logic [DELAY_BITS-1:0]         r_lat;
    logic signed [DELAY_BITS:0]    r_step;
    logic [RAMP_BITS-1:0]          r_cnt;
    logic [IDX_BITS-1:0]           r_wi;
    logic                          r_wrapped;
    logic                          r_byp;
    logic signed [SAMPLE_BITS-1:0] r_l;
    logic signed [SAMPLE_BITS-1:0] r_r;
    logic [IDX_BITS-1:0]           r_i1;
    logic [IDX_BITS-1:0]           r_i2;
    logic [FRAC_BITS-1:0]          r_frac;
    logic                          r_v1;
    logic                          r_v2;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    logic                          in_accept;
    logic [DELAY_BITS-1:0]         t_sat;
    logic                          div_start;
    logic signed [DELAY_BITS:0]    div_num;
    logic                          div_done;
    logic signed [DELAY_BITS:0]    div_quot;
    logic signed [DELAY_BITS:0]    glide_sum;
    logic [SUM_W-1:0]              pos_raw;
    logic [SUM_W-1:0]              pos;
    logic [IDX_BITS-1:0]           i1;
    logic [IDX_BITS-1:0]           i2;
    t_store_ctrl                   store_ctrl;
    logic signed [SAMPLE_BITS-1:0] rd_left1;
    logic signed [SAMPLE_BITS-1:0] rd_left2;
    logic signed [SAMPLE_BITS-1:0] rd_right1;
    logic signed [SAMPLE_BITS-1:0] rd_right2;
    logic signed [SAMPLE_BITS-1:0] a_left;
    logic signed [SAMPLE_BITS-1:0] b_left;
    logic signed [SAMPLE_BITS-1:0] a_right;
    logic signed [SAMPLE_BITS-1:0] b_right;
    logic                          interp_start;
    logic                          done_left;
    logic                          done_right;
    logic signed [SAMPLE_BITS-1:0] y_left;
    logic signed [SAMPLE_BITS-1:0] y_right;
    logic                          out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= DELAY_RESET;
            r_ramp   <= RAMP_RESET;
            r_stereo <= 1'b1;
            r_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: r_target <= i_cfg_data[DELAY_BITS-1:0];
                CFG_RAMP:   r_ramp   <= i_cfg_data[RAMP_BITS-1:0];
                CFG_STEREO: r_stereo <= i_cfg_data[0];
                CFG_BYPASS: r_bypass <= i_cfg_data[0];
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign t_sat      = (r_target > LIMIT) ? LIMIT : r_target;
    assign div_num    = $signed({1'b0, t_sat}) - $signed({1'b0, r_cur});
    assign div_start  = in_accept && !r_bypass && (t_sat != r_lat) && (r_ramp != '0);
    assign glide_sum  = $signed({1'b0, r_cur}) + r_step;

    assign pos_raw = {1'b0, r_wi, {FRAC_BITS{1'b0}}} + SPAN - SUM_W'(r_cur);
    assign pos     = (pos_raw >= SPAN) ? pos_raw - SPAN : pos_raw;
    assign i1      = pos[IDX_BITS+FRAC_BITS-1:FRAC_BITS];
    assign i2      = (i1 == LAST_IDX) ? '0 : i1 + IDX_BITS'(1);

    // Before the first wrap of the write index, entries above it were never written and read as zero.
    // In mono the right entry is written with zero only before the first wrap of the write index.
    assign store_ctrl.we_left  = (r_state == S_WRITE);
    assign store_ctrl.we_right = (r_state == S_WRITE) && (r_stereo || !r_wrapped);
    assign store_ctrl.re       = (r_state == S_READ);

    assign a_left       = r_v1 ? rd_left1  : '0;
    assign b_left       = r_v2 ? rd_left2  : '0;
    assign a_right      = r_v1 ? rd_right1 : '0;
    assign b_right      = r_v2 ? rd_right2 : '0;
    assign interp_start = (r_state == S_LOAD);
    assign out_free     = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= DELAY_RESET;
            r_lat       <= DELAY_RESET;
            r_step      <= '0;
            r_cnt       <= '0;
            r_wi        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_l   <= i_left_in;
                        r_r   <= i_right_in;
                        r_byp <= r_bypass;
                        if (r_bypass) begin
                            r_state <= S_OUT;
                        end else if (t_sat != r_lat) begin
                            r_lat <= t_sat;
                            if (r_ramp == '0) begin
                                r_cur   <= t_sat;
                                r_cnt   <= '0;
                                r_state <= S_GLIDE;
                            end else begin
                                r_cnt   <= r_ramp;
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_state <= S_GLIDE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_step  <= div_quot;
                        r_state <= S_GLIDE;
                    end
                end
                S_GLIDE: begin
                    if (r_cnt == '0) begin
                        r_cur <= r_lat;
                    end else begin
                        r_cnt <= r_cnt - RAMP_BITS'(1);
                        if (r_cnt != RAMP_BITS'(1)) begin
                            r_cur <= glide_sum[DELAY_BITS-1:0];
                        end else begin
                            r_cur <= r_lat;
                        end
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_i1   <= i1;
                    r_i2   <= i2;
                    r_frac <= pos[FRAC_BITS-1:0];
                    r_v1   <= r_wrapped || (i1 <= r_wi);
                    r_v2   <= r_wrapped || (i2 <= r_wi);
                    if (r_wi == LAST_IDX) begin
                        r_wi      <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_wi <= r_wi + IDX_BITS'(1);
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (done_left && done_right) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_byp) begin
                            r_left_out  <= r_l;
                            r_right_out <= r_r;
                        end else begin
                            r_left_out  <= y_left;
                            r_right_out <= r_stereo ? y_right : '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    sfpd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_ramp),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    sfpd_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_ctrl   (store_ctrl),
        .i_waddr  (r_wi),
        .i_wleft  (clamp_sample(r_l)),
        .i_wright (r_stereo ? clamp_sample(r_r) : '0),
        .i_raddr1 (r_i1),
        .i_raddr2 (r_i2),
        .o_left1  (rd_left1),
        .o_left2  (rd_left2),
        .o_right1 (rd_right1),
        .o_right2 (rd_right2)
    );

    sfpd_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (interp_start),
        .i_a     (a_left),
        .i_b     (b_left),
        .i_frac  (r_frac),
        .o_done  (done_left),
        .o_y     (y_left)
    );

    sfpd_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (interp_start),
        .i_a     (a_right),
        .i_b     (b_right),
        .i_frac  (r_frac),
        .o_done  (done_right),
        .o_y     (y_right)
    );

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    `SFPD_ASSERT_NOW(a_div_done_in_div, div_done, r_state == S_DIV, "divider finished outside DIV")
    `SFPD_ASSERT_NOW(a_interp_in_wait, done_left || done_right, r_state == S_WAIT, "early interp")
    `SFPD_ASSERT_NOW(a_delay_in_range, r_state == S_WRITE, r_cur <= LIMIT, "glided delay beyond limit")
    `SFPD_ASSERT_NEXT(a_accept_leaves_idle, in_accept, r_state != S_IDLE, "request accepted but idle")

endmodule

/* verif/smoothed_fractional_predelay_core_tb.sv */
// Self-checking testbench for the smoothed fractional pre-delay core with a frame-level predictor.
module smoothed_fractional_predelay_core_tb;
    import sfpd_pkg::*;

    localparam int SW = DEF_SAMPLE_BITS;
    localparam int DEPTH = DEF_STORE_DEPTH;
    localparam longint DELAY_MASK = (64'd1 << DELAY_BITS) - 1;
    localparam longint DELAY_LIMIT = longint'(DEPTH - 4) << FRAC_BITS;
    localparam longint CLIP_LEVEL = 64'd1 << (SW - 2);
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [SW-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = t_sample'((64'd1 << (SW - 1)) - 1);
    localparam t_sample SAMPLE_MIN = t_sample'(64'd1 << (SW - 1));

    typedef struct {
        t_sample left;
        t_sample right;
    } t_frame;

    class predelay_scoreboard;
        logic [DELAY_BITS-1:0] target_reg;
        logic [RAMP_BITS-1:0] ramp_reg;
        bit stereo_reg;
        bit bypass_reg;
        int store_l[DEPTH];
        int store_r[DEPTH];
        int wr_idx;
        int ramp_left;
        longint cur_delay;
        longint latched;
        longint step;
        t_frame frames_due[$];
        int failures;

        function new();
            target_reg = DELAY_RESET;
            ramp_reg = RAMP_RESET;
            stereo_reg = 1'b1;
            bypass_reg = 1'b0;
            wr_idx = 0;
            ramp_left = 0;
            cur_delay = 65536;
            latched = 65536;
            step = 0;
            failures = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_TARGET: target_reg = data[DELAY_BITS-1:0];
                CFG_RAMP: ramp_reg = data[RAMP_BITS-1:0];
                CFG_STEREO: stereo_reg = data[0];
                CFG_BYPASS: bypass_reg = data[0];
                default: ;
            endcase
        endfunction

        function longint clamp_sample(t_sample s);
            longint v;
            v = longint'(s);
            if (v > CLIP_LEVEL) return CLIP_LEVEL;
            if (v < -CLIP_LEVEL) return -CLIP_LEVEL;
            return v;
        endfunction

        function longint interp(bit right);
            longint span;
            longint pos;
            longint frac;
            longint a;
            longint b;
            int i1;
            int i2;
            span = longint'(DEPTH) << FRAC_BITS;
            pos = ((longint'(wr_idx) << FRAC_BITS) + span - (cur_delay % span)) % span;
            i1 = int'(pos >> FRAC_BITS);
            i2 = (i1 + 1) % DEPTH;
            frac = pos & 64'hFFFF;
            a = longint'(right ? store_r[i1] : store_l[i1]);
            b = longint'(right ? store_r[i2] : store_l[i2]);
            return a + (((b - a) * frac) >>> FRAC_BITS);
        endfunction

        function void take_request(t_sample l, t_sample r);
            longint t;
            longint lo;
            longint ro;
            t_frame f;
            if (bypass_reg) begin
                f.left = l;
                f.right = r;
                frames_due.push_back(f);
                return;
            end
            t = longint'(target_reg);
            if (t > DELAY_LIMIT) t = DELAY_LIMIT;
            if (t > DELAY_MASK) t = DELAY_MASK;
            if (t != latched) begin
                latched = t;
                if (ramp_reg == 0) begin
                    cur_delay = t;
                    ramp_left = 0;
                end else begin
                    ramp_left = int'(ramp_reg);
                    step = (t - cur_delay) / longint'(ramp_reg);
                end
            end
            if (ramp_left == 0) begin
                cur_delay = latched;
            end else begin
                ramp_left--;
                if (ramp_left > 0) cur_delay = (cur_delay + step) & DELAY_MASK;
                else cur_delay = latched;
            end
            store_l[wr_idx] = int'(clamp_sample(l));
            lo = interp(1'b0);
            ro = 0;
            if (stereo_reg) begin
                store_r[wr_idx] = int'(clamp_sample(r));
                ro = interp(1'b1);
            end
            wr_idx = (wr_idx + 1) % DEPTH;
            f.left = t_sample'(lo);
            f.right = t_sample'(ro);
            frames_due.push_back(f);
        endfunction

        function void report(string what, t_sample want, t_sample got);
            failures++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
        endfunction

        function void check_result(t_sample l, t_sample r);
            t_frame f;
            if (frames_due.size() == 0) begin
                failures++;
                $display("%0t unexpected result: expected none actual %0d %0d",
                         $time, l, r);
                return;
            end
            f = frames_due.pop_front();
            if (l !== f.left) report("left", f.left, l);
            if (r !== f.right) report("right", f.right, r);
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    t_sample i_left_in;
    t_sample i_right_in;
    logic o_out_valid;
    logic i_out_stall;
    t_sample o_left_out;
    t_sample o_right_out;

    predelay_scoreboard sb;
    int send_idle;
    int recv_idle;
    bit hold_go;
    int quiet_cycles = 0;

    smoothed_fractional_predelay_core u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_left_in(i_left_in),
        .i_right_in(i_right_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_left_out(o_left_out),
        .o_right_out(o_right_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_left_out, o_right_out);
            if (i_in_valid && !o_in_stall) sb.take_request(i_left_in, i_right_in);
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic send_frame(t_sample l, t_sample r);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_left_in <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return t_sample'(CLIP_LEVEL + longint'($urandom_range(2)) - 1);
            3: return t_sample'(-CLIP_LEVEL - longint'($urandom_range(2)) + 1);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) send_frame(rand_sample(), rand_sample());
    endtask

    task automatic pick_config();
        logic [DELAY_BITS-1:0] tgt;
        logic [RAMP_BITS-1:0] rmp;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: tgt = DELAY_BITS'($urandom_range(0, 8 << FRAC_BITS));
            6: tgt = '0;
            7: tgt = DELAY_BITS'($urandom);
            8: tgt = DELAY_BITS'($urandom_range(0, 300 << FRAC_BITS));
            default: tgt = DELAY_BITS'(DELAY_LIMIT);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: rmp = '0;
            4, 5, 6, 7: rmp = RAMP_BITS'($urandom_range(1, 12));
            8: rmp = '1;
            default: rmp = RAMP_BITS'($urandom_range(13, 200));
        endcase
        write_reg(CFG_RAMP, CFG_DATA_BITS'(rmp));
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_STEREO, CFG_DATA_BITS'($urandom_range(1)));
        write_reg(CFG_BYPASS, CFG_DATA_BITS'($urandom_range(9) == 0));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TARGET;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_left_in = '0;
        i_right_in = '0;
        send_idle = 10;
        recv_idle = 10;
        hold_go = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(t_sample'(CLIP_LEVEL), t_sample'(-CLIP_LEVEL));
        send_frame(t_sample'(CLIP_LEVEL + 1), t_sample'(-CLIP_LEVEL - 1));
        send_frame('0, '0);
        send_frame(t_sample'(-1), t_sample'(1));

        wait_idle();
        write_reg(CFG_RAMP, '0);
        write_reg(CFG_TARGET, 30'h0001_8000);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(t_sample'(12345), t_sample'(-12345));
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN);
        send_frame('0, t_sample'(-1));

        wait_idle();
        write_reg(CFG_RAMP, CFG_DATA_BITS'(3));
        write_reg(CFG_TARGET, 30'h3FFF_FFFF);
        send_random(4);

        wait_idle();
        write_reg(CFG_RAMP, CFG_DATA_BITS'(5));
        write_reg(CFG_TARGET, 30'h0000_8000);
        send_random(6);

        wait_idle();
        write_reg(CFG_TARGET, '0);
        write_reg(CFG_RAMP, '0);
        write_reg(CFG_STEREO, CFG_DATA_BITS'(0));
        send_random(3);

        wait_idle();
        write_reg(CFG_BYPASS, CFG_DATA_BITS'(1));
        send_random(2);
        wait_idle();
        write_reg(CFG_STEREO, CFG_DATA_BITS'(1));
        send_random(1);
        wait_idle();
        write_reg(CFG_BYPASS, CFG_DATA_BITS'(0));

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 28 : (ph == 1) ? 68 : 0;
            recv_idle = (ph == 0) ? 68 : (ph == 1) ? 28 : 0;
            for (int chunk = 0; chunk < 3; chunk++) begin
                wait_idle();
                pick_config();
                if (ph == 2 && chunk == 1) hold_go = 1'b1;
                send_random(50);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
